@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL files; the top-level queue includes them.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/teq_pkg.sv @@
`timescale 1ns / 1ps

package teq_pkg;

    localparam int TIME_W = 63;
    localparam int ID_W   = 4;
    localparam int OP_W   = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic KIND_FIRE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] interval;
    } cmd_item_t;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   fired_id;
        logic              head_valid;
        logic [TIME_W-1:0] next_expiry;
        logic              reprogram;
        logic              last;
    } evt_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   owner;
        logic [TIME_W-1:0] expiry;
    } slot_entry_t;

    typedef enum logic [1:0] {
        SLOT_HOLD,
        SLOT_REMOVE,
        SLOT_INSERT
    } slot_op_t;

    typedef struct packed {
        slot_op_t    code;
        slot_entry_t entry;
    } slot_cmd_t;

    typedef struct packed {
        logic id_match;
        logic key_before;
    } cmp_res_t;

endpackage

@@ rtl/teq_cmp.sv @@
`timescale 1ns / 1ps

// Shared compare unit: identity match and strict time order against one slot.
module teq_cmp
    import teq_pkg::*;
(
    input  slot_entry_t       entry,
    input  logic [ID_W-1:0]   key_id,
    input  logic [TIME_W-1:0] key_time,
    output cmp_res_t          res
);

    assign res.id_match   = (entry.owner == key_id);
    assign res.key_before = (key_time < entry.expiry);

endmodule

@@ rtl/teq_slots.sv @@
`timescale 1ns / 1ps

// Sorted slot chain: remove shifts the tail down, insert shifts it up.
module teq_slots
    import teq_pkg::*;
#(
    parameter  int DEPTH = 16,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  slot_cmd_t        cmd,
    input  logic [IDX_W-1:0] pos,
    input  logic [IDX_W-1:0] rd_idx,
    output slot_entry_t      rd_entry,
    output slot_entry_t      head
);

    slot_entry_t slot_q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        localparam logic [IDX_W-1:0] I_IDX = IDX_W'(i);
        always_ff @(posedge clk)
        begin
            unique case (cmd.code)
                SLOT_REMOVE:
                begin
                    if (i < DEPTH - 1 && I_IDX >= pos) begin
                        slot_q[i] <= slot_q[(i < DEPTH - 1) ? i + 1 : i];
                    end
                end
                SLOT_INSERT:
                begin
                    if (I_IDX == pos) begin
                        slot_q[i] <= cmd.entry;
                    end else if (i > 0 && I_IDX > pos) begin
                        slot_q[i] <= slot_q[(i > 0) ? i - 1 : i];
                    end
                end
                default:
                begin
                    slot_q[i] <= slot_q[i];
                end
            endcase
        end
    end

    assign rd_entry = slot_q[rd_idx];
    assign head     = slot_q[0];

endmodule

@@ rtl/timer_expiry_queue_top.sv @@
// Sorted timer queue: keeps up to TIMER_COUNT timers in expiry order (ties in
// insertion order) and handles one command transaction at a time. A start
// removes the timer if queued, then inserts it at now + interval (saturated to
// the maximum time); a cancel removes it; a tick fires every timer due at now,
// one fire transaction each, in queue order. Every command ends with a status
// transaction (last = 1) carrying the head expiry and the reprogram flag. One
// shared comparator walks the slot chain one position per cycle, so the time
// from acceptance to status grows with the number of queued timers for a start
// or a cancel and with the number of fired timers for a tick; the linear search
// sets this, and a stalled event channel holds a fire or status transaction
// back. The next command is taken in the cycle after the status transaction
// is loaded, while that status may still wait.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module timer_expiry_queue_top
    import teq_pkg::*;
#(
    parameter int TIMER_COUNT = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      evt_valid,
    input  logic      evt_stall,
    output evt_item_t evt
);

    localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CNT_W = $clog2(TIMER_COUNT + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TIMER_COUNT);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_PLACE,
        S_FIRE,
        S_STATUS
    } state_t;

    state_t            state_reg,   state_next;
    logic [OP_W-1:0]   op_reg,      op_next;
    logic [ID_W-1:0]   id_reg,      id_next;
    logic [TIME_W-1:0] now_reg,     now_next;
    logic [TIME_W-1:0] due_reg,     due_next;
    logic [CNT_W-1:0]  ptr_reg,     ptr_next;
    logic [CNT_W-1:0]  len_reg,     len_next;
    logic              reprog_reg,  reprog_next;
    logic              evt_valid_reg, evt_valid_next;
    evt_item_t         evt_reg,     evt_next;

    slot_cmd_t         slot_cmd;
    slot_entry_t       rd_entry;
    slot_entry_t       head;
    cmp_res_t          cmp;
    logic [TIME_W-1:0] key_time;
    logic [TIME_W:0]   sum;
    logic              out_free;
    logic              id_ok;

    // Saturating expiry: a carry out of the time width clamps to the maximum.
    assign sum   = {1'b0, cmd.now} + {1'b0, cmd.interval};
    assign id_ok = (int'(cmd.timer_id) < TIMER_COUNT);

    // Ticks compare the head against now, starts compare slots against the due time.
    assign key_time = (op_reg == OP_TICK) ? now_reg : due_reg;

    // The result register can take a new transaction when empty or being drained.
    assign out_free = !evt_valid_reg || !evt_stall;

    assign cmd_stall = (state_reg != S_IDLE);
    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

    teq_slots #(
        .DEPTH (TIMER_COUNT)
    ) u_slots (
        .clk      (clk),
        .cmd      (slot_cmd),
        .pos      (ptr_reg[IDX_W-1:0]),
        .rd_idx   (ptr_reg[IDX_W-1:0]),
        .rd_entry (rd_entry),
        .head     (head)
    );

    teq_cmp u_cmp (
        .entry    (rd_entry),
        .key_id   (id_reg),
        .key_time (key_time),
        .res      (cmp)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        now_next       = now_reg;
        due_next       = due_reg;
        ptr_next       = ptr_reg;
        len_next       = len_reg;
        reprog_next    = reprog_reg;
        evt_valid_next = evt_valid_reg;
        evt_next       = evt_reg;

        slot_cmd.code         = SLOT_HOLD;
        slot_cmd.entry.owner  = id_reg;
        slot_cmd.entry.expiry = due_reg;

        // Drop the pending result once the consumer takes it.
        if (evt_valid_reg && !evt_stall) begin
            evt_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid) begin
                    op_next     = cmd.op;
                    id_next     = cmd.timer_id;
                    now_next    = cmd.now;
                    due_next    = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                    ptr_next    = '0;
                    reprog_next = 1'b0;
                    priority if ((cmd.op == OP_START || cmd.op == OP_CANCEL) && id_ok) begin
                        state_next = S_FIND;
                    end else if (cmd.op == OP_TICK) begin
                        state_next = S_FIRE;
                    end else begin
                        state_next = S_STATUS;
                    end
                end
            end
            S_FIND:
            begin
                // Walk the chain for the timer; remove it where it matches.
                priority if (ptr_reg == len_reg || cmp.id_match) begin
                    if (ptr_reg != len_reg) begin
                        slot_cmd.code = SLOT_REMOVE;
                        len_next      = len_reg - CNT_ONE;
                        reprog_next   = (ptr_reg == '0) && (len_reg > CNT_ONE);
                    end
                    ptr_next   = '0;
                    state_next = (op_reg == OP_START) ? S_PLACE : S_STATUS;
                end else begin
                    ptr_next = ptr_reg + CNT_ONE;
                end
            end
            S_PLACE:
            begin
                // Stop at the first slot that expires strictly later.
                priority if (ptr_reg == len_reg || cmp.key_before) begin
                    if (len_reg < DEPTH_CNT) begin
                        slot_cmd.code = SLOT_INSERT;
                        len_next      = len_reg + CNT_ONE;
                        if (ptr_reg == '0) begin
                            reprog_next = 1'b1;
                        end
                    end
                    state_next = S_STATUS;
                end else begin
                    ptr_next = ptr_reg + CNT_ONE;
                end
            end
            S_FIRE:
            begin
                // Fire the head while it is due, one transaction per cycle unless the event channel stalls.
                priority if (len_reg == '0 || cmp.key_before) begin
                    reprog_next = (len_reg != '0);
                    state_next  = S_STATUS;
                end else if (out_free) begin
                    slot_cmd.code        = SLOT_REMOVE;
                    len_next             = len_reg - CNT_ONE;
                    evt_valid_next       = 1'b1;
                    evt_next.kind        = KIND_FIRE;
                    evt_next.fired_id    = head.owner;
                    evt_next.head_valid  = 1'b0;
                    evt_next.next_expiry = '0;
                    evt_next.reprogram   = 1'b0;
                    evt_next.last        = 1'b0;
                end
            end
            S_STATUS:
            begin
                if (out_free) begin
                    evt_valid_next       = 1'b1;
                    evt_next.kind        = KIND_STATUS;
                    evt_next.fired_id    = '0;
                    evt_next.head_valid  = (len_reg != '0);
                    evt_next.next_expiry = (len_reg != '0) ? head.expiry : '0;
                    evt_next.reprogram   = reprog_reg;
                    evt_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            id_reg        <= '0;
            now_reg       <= '0;
            due_reg       <= '0;
            len_reg       <= '0;
            ptr_reg       <= '0;
            reprog_reg    <= 1'b0;
            evt_valid_reg <= 1'b0;
            evt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            id_reg        <= id_next;
            now_reg       <= now_next;
            due_reg       <= due_next;
            len_reg       <= len_next;
            ptr_reg       <= ptr_next;
            reprog_reg    <= reprog_next;
            evt_valid_reg <= evt_valid_next;
            evt_reg       <= evt_next;
        end
    end

    `ASSERT_IMPL(a_len_bound, 1'b1, len_reg <= DEPTH_CNT, "queue length beyond capacity")
    `ASSERT_IMPL(a_remove_nonempty, slot_cmd.code == SLOT_REMOVE, len_reg != '0,
                 "removal from an empty queue")
    `ASSERT_IMPL(a_insert_room, slot_cmd.code == SLOT_INSERT,
                 (len_reg < DEPTH_CNT) && (ptr_reg <= len_reg), "insertion past the queue end")
    `ASSERT_NEXT(a_fire_on_tick, state_reg == S_FIRE && slot_cmd.code == SLOT_REMOVE,
                 evt_valid_reg && evt_reg.kind == KIND_FIRE && op_reg == OP_TICK,
                 "fire transaction not loaded on head removal")

endmodule
